// ----- hdl/rme_pkg.sv -----
`default_nettype none
package rme_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int NUM_STEPS  = WORD_WIDTH * WORD_WIDTH;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_idx_t;

  // acc: running power; b: current base (multiplier bits)
  // pacc/pa: acc*base in progress; qacc/qa: base*base in progress
  typedef struct packed {
    word_t acc;
    word_t b;
    word_t pacc;
    word_t pa;
    word_t qacc;
    word_t qa;
  } lane_t;

  // (a + b) mod m for a, b below m
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    word_t gap;
    gap = m - b;
    if (a >= gap) begin
      add_mod = a - gap;
    end else begin
      add_mod = a + b;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rme_mul_step.sv -----
`default_nettype none
module rme_mul_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           vld_in,
  input  wire rme_pkg::lane_t lane_in,
  input  wire rme_pkg::word_t modulus,
  input  wire logic           step_bit,
  input  wire logic           last,
  input  wire logic           ebit,
  output logic                vld_out,
  output rme_pkg::lane_t      lane_out
);

  rme_pkg::lane_t lane_nxt;
  rme_pkg::word_t acc_new;
  logic           vld_r;
  rme_pkg::lane_t lane_r;

  always_comb begin
    lane_nxt      = lane_in;
    acc_new       = lane_in.acc;
    if (step_bit) begin
      lane_nxt.pacc = rme_pkg::add_mod(lane_in.pacc, lane_in.pa, modulus);
      lane_nxt.qacc = rme_pkg::add_mod(lane_in.qacc, lane_in.qa, modulus);
    end
    lane_nxt.pa = rme_pkg::add_mod(lane_in.pa, lane_in.pa, modulus);
    lane_nxt.qa = rme_pkg::add_mod(lane_in.qa, lane_in.qa, modulus);
    // close one exponent bit: take the product if set, square the base
    if (last) begin
      if (ebit) begin
        acc_new = lane_nxt.pacc;
      end
      lane_nxt.acc  = acc_new;
      lane_nxt.b    = lane_nxt.qacc;
      lane_nxt.pa   = acc_new;
      lane_nxt.qa   = lane_nxt.qacc;
      lane_nxt.pacc = '0;
      lane_nxt.qacc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign lane_out = lane_r;

endmodule
`default_nettype wire

// ----- hdl/rsa_modular_exponentiation.sv -----
`default_nettype none
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_value   (32 bits)
// out      out_valid / out_ready   out_result (32 bits)
// cfg      cfg_we                  cfg_index, cfg_data (32 bits)
// One item enters per cycle while the pipeline advances; each result passes
// WORD_WIDTH restoring steps that reduce the input, then one add-and-double
// step per stage for each exponent bit times each base bit.
// The whole pipeline advances together; it holds while a result waits.
// Reset clears the valid bits and sets exponent and modulus to 1.
module rsa_modular_exponentiation (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rme_pkg::word_t in_value,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rme_pkg::word_t      out_result,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire rme_pkg::word_t cfg_data
);

  localparam int W  = rme_pkg::WORD_WIDTH;
  localparam int NS = rme_pkg::NUM_STEPS;

  rme_pkg::word_t exponent_r;
  rme_pkg::word_t modulus_r;
  logic           adv;

  logic           red_vld [0:W];
  rme_pkg::word_t red_val [0:W];
  rme_pkg::word_t red_rem [0:W];

  logic           mul_vld  [0:NS];
  rme_pkg::lane_t mul_lane [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= rme_pkg::word_t'(1);
      modulus_r  <= rme_pkg::word_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rme_pkg::CFG_EXPONENT: exponent_r <= cfg_data;
        rme_pkg::CFG_MODULUS:  modulus_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !mul_vld[NS] || out_ready;
  assign in_ready = adv;

  assign red_vld[0] = in_valid;
  assign red_val[0] = in_value;
  assign red_rem[0] = '0;

  // restoring reduction, one dividend bit per stage, MSB first
  for (genvar i = 0; i < W; i++) begin : g_red
    logic [W:0]     trial;
    rme_pkg::word_t rem_nxt;
    logic           vld_r;
    rme_pkg::word_t val_r;
    rme_pkg::word_t rem_r;

    always_comb begin
      trial   = {red_rem[i], red_val[i][W-1-i]};
      rem_nxt = trial[W-1:0];
      if (trial >= {1'b0, modulus_r}) begin
        rem_nxt = W'(trial - {1'b0, modulus_r});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= red_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        val_r <= red_val[i];
        rem_r <= rem_nxt;
      end
    end

    assign red_vld[i+1] = vld_r;
    assign red_val[i+1] = val_r;
    assign red_rem[i+1] = rem_r;
  end

  assign mul_vld[0]       = red_vld[W];
  assign mul_lane[0].acc  = rme_pkg::word_t'(1);
  assign mul_lane[0].b    = red_rem[W];
  assign mul_lane[0].pacc = '0;
  assign mul_lane[0].pa   = rme_pkg::word_t'(1);
  assign mul_lane[0].qacc = '0;
  assign mul_lane[0].qa   = red_rem[W];

  for (genvar s = 0; s < NS; s++) begin : g_mul
    localparam int J = s / W;
    localparam int K = s % W;

    rme_mul_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .vld_in   (mul_vld[s]),
      .lane_in  (mul_lane[s]),
      .modulus  (modulus_r),
      .step_bit (mul_lane[s].b[K]),
      .last     (K == W - 1),
      .ebit     (exponent_r[J]),
      .vld_out  (mul_vld[s+1]),
      .lane_out (mul_lane[s+1])
    );
  end

  // modulus of one or zero gives zero
  assign out_valid  = mul_vld[NS];
  assign out_result = (modulus_r <= rme_pkg::word_t'(1)) ? '0 : mul_lane[NS].acc;

endmodule
`default_nettype wire
